>>> design/tksk_pkg.sv
// ----------------------------------------------------------------------------
// tksk_pkg - shared types and constants for the top-k score keeper
// sizes, entry record, cell command codes and the drain ranking function
// ----------------------------------------------------------------------------
package tksk_pkg;

    localparam int MAX_KEEP = 16;
    localparam int ID_W     = 31;
    localparam int SCORE_W  = 32;
    localparam int AGE_W    = 32;
    localparam int KEEP_W   = 5;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    // input item operations
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // cell commands
    localparam logic [1:0] CMD_HOLD     = 2'd0;
    localparam logic [1:0] CMD_APPEND   = 2'd1;
    localparam logic [1:0] CMD_REPLACE  = 2'd2;
    localparam logic [1:0] CMD_SHIFT_UP = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [SCORE_W-1:0] score;
        logic [AGE_W-1:0]          age;
    } entry_t;

    // broadcast from the control to every cell
    typedef struct packed {
        logic [1:0]                cmd;
        entry_t                    new_entry;
        logic signed [SCORE_W-1:0] tail_score;
    } cell_ctrl_t;

    // handed from each cell to the one below it
    typedef struct packed {
        logic below;    // new item ranks above this cell (or cell empty)
        logic seen;     // eviction target at or above this cell
        logic tail_eq;  // this cell holds the lowest score
    } cell_link_t;

    // true when a ranks above b in drain order
    function automatic logic ranks_above(input entry_t a, input entry_t b);
        logic higher;
        logic same;
        higher = $signed(a.score) > $signed(b.score);
        same   = a.score == b.score;
        return higher || (same && (a.age < b.age));
    endfunction

endpackage

>>> design/tksk_cand_if.sv
// ----------------------------------------------------------------------------
// tksk_cand_if - candidate item channel
// valid/ready channel carrying an insert or drain request
// ----------------------------------------------------------------------------
interface tksk_cand_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [tksk_pkg::ID_W-1:0]           entry_id;
    logic signed [tksk_pkg::SCORE_W-1:0] score;

    modport source (output valid, output op, output entry_id, output score, input ready);
    modport sink   (input valid, input op, input entry_id, input score, output ready);
endinterface

>>> design/tksk_result_if.sv
// ----------------------------------------------------------------------------
// tksk_result_if - result item channel
// valid/ready channel carrying one drained pair
// ----------------------------------------------------------------------------
interface tksk_result_if;
    logic                                valid;
    logic                                ready;
    logic [tksk_pkg::ID_W-1:0]           out_id;
    logic signed [tksk_pkg::SCORE_W-1:0] out_score;
    logic                                is_empty;
    logic                                last;

    modport source (output valid, output out_id, output out_score, output is_empty,
                    output last, input ready);
    modport sink   (input valid, input out_id, input out_score, input is_empty,
                    input last, output ready);
endinterface

>>> design/tksk_cfg_if.sv
// ----------------------------------------------------------------------------
// tksk_cfg_if - configuration write channel
// valid/ready channel carrying the keep count
// ----------------------------------------------------------------------------
interface tksk_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tksk_pkg::KEEP_W-1:0]      keep_count;

    modport source (output valid, output keep_count, input ready);
    modport sink   (input valid, input keep_count, output ready);
endinterface

>>> design/tksk_cell.sv
// ----------------------------------------------------------------------------
// tksk_cell - one slot of the sorted chain
// holds one pair; inserts, shifts down behind an insert, or shifts up on drain
// ----------------------------------------------------------------------------
module tksk_cell (
    input  logic                 clk,
    input  tksk_pkg::cell_ctrl_t ctrl,
    input  logic                 valid_self,
    input  logic                 valid_prev,
    input  tksk_pkg::entry_t     prev_entry,
    input  tksk_pkg::entry_t     next_entry,
    input  tksk_pkg::cell_link_t link_prev,
    output tksk_pkg::cell_link_t link_out,
    output tksk_pkg::entry_t     entry
);

    tksk_pkg::entry_t entry_reg;
    logic             below;
    logic             tail_eq;
    logic             evict;
    logic             ins_here;

    assign below    = !valid_self || tksk_pkg::ranks_above(ctrl.new_entry, entry_reg);
    assign tail_eq  = valid_self && (entry_reg.score == ctrl.tail_score);
    assign evict    = tail_eq && !link_prev.tail_eq;
    assign ins_here = below && !link_prev.below;

    assign link_out.below   = below;
    assign link_out.seen    = link_prev.seen || evict;
    assign link_out.tail_eq = tail_eq;
    assign entry            = entry_reg;

    always_ff @(posedge clk)
    begin
        unique case (ctrl.cmd)
            tksk_pkg::CMD_HOLD:
            begin
                entry_reg <= entry_reg;
            end
            tksk_pkg::CMD_APPEND:
            begin
                if (ins_here)
                begin
                    entry_reg <= ctrl.new_entry;
                end
                else if (link_prev.below && valid_prev)
                begin
                    entry_reg <= prev_entry;
                end
            end
            tksk_pkg::CMD_REPLACE:
            begin
                // cells between the insert point and the evicted slot move down
                if (ins_here)
                begin
                    entry_reg <= ctrl.new_entry;
                end
                else if (link_prev.below && !link_prev.seen)
                begin
                    entry_reg <= prev_entry;
                end
            end
            tksk_pkg::CMD_SHIFT_UP:
            begin
                entry_reg <= next_entry;
            end
        endcase
    end

endmodule

>>> design/tksk_chain.sv
// ----------------------------------------------------------------------------
// tksk_chain - row of sorted cells
// cell 0 holds the best pair; the lowest held pair sits at held_count - 1
// ----------------------------------------------------------------------------
module tksk_chain (
    input  logic                          clk,
    input  logic [1:0]                    cmd,
    input  tksk_pkg::entry_t              new_entry,
    input  logic [tksk_pkg::CNT_W-1:0]    held_count,
    output tksk_pkg::entry_t              head,
    output logic signed [tksk_pkg::SCORE_W-1:0] tail_score
);

    tksk_pkg::entry_t     entries [tksk_pkg::MAX_KEEP];
    tksk_pkg::cell_link_t links   [tksk_pkg::MAX_KEEP];
    tksk_pkg::cell_ctrl_t ctrl;
    logic [tksk_pkg::CNT_W-1:0] tail_pos;

    assign tail_pos   = held_count - tksk_pkg::CNT_W'(1);
    assign tail_score = entries[tail_pos[tksk_pkg::IDX_W-1:0]].score;

    assign ctrl.cmd        = cmd;
    assign ctrl.new_entry  = new_entry;
    assign ctrl.tail_score = tail_score;

    assign head = entries[0];

    for (genvar i = 0; i < tksk_pkg::MAX_KEEP; i++)
    begin : g_cell
        tksk_pkg::entry_t     prev_e;
        tksk_pkg::entry_t     next_e;
        tksk_pkg::cell_link_t prev_l;
        logic                 v_prev;
        logic                 v_self;

        assign v_self = held_count > tksk_pkg::CNT_W'(i);

        if (i == 0)
        begin : g_first
            assign prev_e = new_entry;
            assign prev_l = '0;
            assign v_prev = 1'b0;
        end
        else
        begin : g_rest
            assign prev_e = entries[i-1];
            assign prev_l = links[i-1];
            assign v_prev = held_count > tksk_pkg::CNT_W'(i - 1);
        end

        if (i == tksk_pkg::MAX_KEEP - 1)
        begin : g_last
            assign next_e = entries[i];
        end
        else
        begin : g_mid
            assign next_e = entries[i+1];
        end

        tksk_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .valid_self (v_self),
            .valid_prev (v_prev),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .link_prev  (prev_l),
            .link_out   (links[i]),
            .entry      (entries[i])
        );
    end

endmodule

>>> design/top_k_score_keeper_core.sv
// insert items: one per cycle, no result; the chain cells update in the cycle of acceptance
// drain items: held pairs leave (or one empty item when none are held) one per
//   cycle from the head of the cell chain while the output register is free
// no new item is taken until a drain has handed its last pair to the output register
// reset: held count, arrival counter, drain flag and output valid clear, keep count to 16
// ----------------------------------------------------------------------------
// top_k_score_keeper_core - keeps the best scoring pairs in a sorted cell chain
// the chain stays in drain order (score down, then arrival); a drain reads the
// head and shifts the chain up one cell per result
// ----------------------------------------------------------------------------
module top_k_score_keeper_core (
    input  logic clk,
    input  logic rst_n,
    tksk_cand_if.sink     cand,
    tksk_cfg_if.sink      cfg,
    tksk_result_if.source result
);

    localparam int CNT_W = tksk_pkg::CNT_W;

    logic [tksk_pkg::KEEP_W-1:0]  keep_reg;
    logic [CNT_W-1:0]             held_reg;
    logic [CNT_W-1:0]             held_next;
    logic [tksk_pkg::AGE_W-1:0]   arrival_reg;
    logic                         drain_reg;
    logic                         out_valid_reg;
    logic [tksk_pkg::ID_W-1:0]    out_id_reg;
    logic signed [tksk_pkg::SCORE_W-1:0] out_score_reg;
    logic                         out_empty_reg;
    logic                         out_last_reg;

    logic [CNT_W-1:0]             keep_eff;
    logic                         cand_take;
    logic                         do_insert;
    logic                         do_append;
    logic                         slot_free;
    logic                         emit;
    logic [1:0]                   cmd;
    tksk_pkg::entry_t             new_entry;
    tksk_pkg::entry_t             head;
    logic signed [tksk_pkg::SCORE_W-1:0] tail_score;

    // keep count clamped to 1..MAX_KEEP
    always_comb
    begin
        priority if (keep_reg == '0)
        begin
            keep_eff = CNT_W'(1);
        end
        else if (int'(keep_reg) > tksk_pkg::MAX_KEEP)
        begin
            keep_eff = CNT_W'(tksk_pkg::MAX_KEEP);
        end
        else
        begin
            keep_eff = CNT_W'(keep_reg);
        end
    end

    // handshakes
    assign cfg.ready  = 1'b1;
    assign cand.ready = !drain_reg;
    assign cand_take  = cand.valid && cand.ready;
    assign do_insert  = cand_take && (cand.op == tksk_pkg::OP_INSERT);
    assign do_append  = do_insert && (held_reg < keep_eff);

    // output register accepts a new item when empty or being taken
    assign slot_free = !out_valid_reg || result.ready;
    assign emit      = drain_reg && slot_free;

    assign new_entry.id    = cand.entry_id;
    assign new_entry.score = cand.score;
    assign new_entry.age   = arrival_reg;

    // chain command
    always_comb
    begin
        cmd       = tksk_pkg::CMD_HOLD;
        held_next = held_reg;
        if (do_append)
        begin
            cmd       = tksk_pkg::CMD_APPEND;
            held_next = held_reg + CNT_W'(1);
        end
        else if (do_insert && ($signed(cand.score) > $signed(tail_score)))
        begin
            // full: strictly better than the lowest held pair evicts it
            cmd = tksk_pkg::CMD_REPLACE;
        end
        else if (emit && (held_reg != '0))
        begin
            cmd       = tksk_pkg::CMD_SHIFT_UP;
            held_next = held_reg - CNT_W'(1);
        end
    end

    tksk_chain u_chain (
        .clk        (clk),
        .cmd        (cmd),
        .new_entry  (new_entry),
        .held_count (held_reg),
        .head       (head),
        .tail_score (tail_score)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg      <= tksk_pkg::KEEP_W'(16);
            held_reg      <= '0;
            arrival_reg   <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                keep_reg <= cfg.keep_count;
            end

            held_reg <= held_next;

            if (do_insert)
            begin
                arrival_reg <= arrival_reg + tksk_pkg::AGE_W'(1);
            end
            else if (cand_take)
            begin
                // a drain restarts the arrival stamps
                arrival_reg <= '0;
            end

            if (cand_take && (cand.op == tksk_pkg::OP_DRAIN))
            begin
                drain_reg <= 1'b1;
            end
            else if (emit && (held_reg <= CNT_W'(1)))
            begin
                drain_reg <= 1'b0;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            if (held_reg == '0)
            begin
                out_id_reg    <= '0;
                out_score_reg <= '0;
                out_empty_reg <= 1'b1;
                out_last_reg  <= 1'b1;
            end
            else
            begin
                out_id_reg    <= head.id;
                out_score_reg <= head.score;
                out_empty_reg <= 1'b0;
                out_last_reg  <= (held_reg == CNT_W'(1));
            end
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.out_id    = out_id_reg;
    assign result.out_score = out_score_reg;
    assign result.is_empty  = out_empty_reg;
    assign result.last      = out_last_reg;

    // checks
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CNT_W'(tksk_pkg::MAX_KEEP))
        else $error("held count beyond chain length");

    a_drain_ends_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(drain_reg) |-> held_reg == '0)
        else $error("drain finished with pairs still held");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> held_reg == $past(held_reg) + CNT_W'(1))
        else $error("append did not grow held count");

    a_drain_restamps: assert property (@(posedge clk) disable iff (!rst_n)
        (cand_take && (cand.op == tksk_pkg::OP_DRAIN)) |=> arrival_reg == '0 && drain_reg)
        else $error("drain did not restart arrival stamps");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && held_reg <= CNT_W'(1)) |=> out_valid_reg && out_last_reg && !drain_reg)
        else $error("final drain item not marked last");

endmodule
